>>> rtl/gdr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gdr_pkg: shared types and codes for the genotype dense recoder
// Beat payload structs, item kinds, error codes and sequencer states.
// ---------------------------------------------------------------------------
package gdr_pkg;

    localparam logic [2:0] KIND_START   = 3'd0;
    localparam logic [2:0] KIND_FOUNDER = 3'd1;
    localparam logic [2:0] KIND_HET     = 3'd2;
    localparam logic [2:0] KIND_CLOSE   = 3'd3;
    localparam logic [2:0] KIND_FINAL   = 3'd4;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value_a;
        logic signed [31:0] value_b;
        logic signed [31:0] value_c;
        logic               is_missing;
        logic               first_marker;
    } in_beat_t;

    typedef struct packed {
        logic [6:0] code_a;
        logic [3:0] code_b;
        logic [6:0] code_c;
        logic [5:0] row_index;
        logic       pending;
        logic       missing_out;
        logic [1:0] error;
        logic [6:0] max_alleles;
        logic       last;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FSCAN,
        ST_HSCAN,
        ST_HSCAN2,
        ST_LRD,
        ST_LFSCAN,
        ST_LHSCAN,
        ST_EMIT,
        ST_WAIT
    } state_t;

endpackage

>>> rtl/gdr_match.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gdr_match: shared compare unit
// Equality and signed less-than of one probe against one table entry.
// ---------------------------------------------------------------------------
module gdr_match (
    input  logic signed [31:0] probe,
    input  logic signed [31:0] entry,
    output logic               eq,
    output logic               lt
);
    assign eq = (probe == entry);
    assign lt = (entry < probe);
endmodule

>>> rtl/genotype_dense_recoder.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// genotype_dense_recoder: per-marker dictionary recoder
// Sequencer over founder and het tables with one shared compare unit.
// ---------------------------------------------------------------------------
// A founder item scans the founder table. A het row scans the founder table
// for value_a and value_b and, when both hit and differ, the het table for value_c.
// A final that is not missing scans the founder and het tables; a close does
// so for each pending label, and a label's beat waits for m_ready before the
// next label starts. Start items and a close with nothing pending stay in
// idle and give no result beat. The single compare unit steps one table
// entry a cycle. s_ready is low while an item is in work or its result beat
// waits. No clearing pass: tables are tracked by counts.
module genotype_dense_recoder #(
    parameter int MAX_FOUNDER_ALLELES = 16,
    parameter int MAX_HET_ROWS        = 63
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  gdr_pkg::in_beat_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output gdr_pkg::out_beat_t  m_data
);
    localparam int FW = $clog2(MAX_FOUNDER_ALLELES);
    localparam int FC = $clog2(MAX_FOUNDER_ALLELES + 1);
    localparam int HW = (MAX_HET_ROWS > 1) ? $clog2(MAX_HET_ROWS) : 1;
    localparam int HC = $clog2(MAX_HET_ROWS + 1);

    logic signed [31:0] fval_mem [MAX_FOUNDER_ALLELES];
    logic signed [31:0] hval_mem [MAX_HET_ROWS];
    logic signed [31:0] plab_mem [MAX_HET_ROWS];
    logic [5:0]         prow_mem [MAX_HET_ROWS];

    gdr_pkg::state_t state_reg, state_next;
    gdr_pkg::in_beat_t in_reg, in_next;
    gdr_pkg::out_beat_t out_reg, out_next;
    logic [FC-1:0] fcnt_reg, fcnt_next;
    logic [HC-1:0] hcnt_reg, hcnt_next;
    logic [HC-1:0] pcnt_reg, pcnt_next;
    logic [HC-1:0] row_reg, row_next;
    logic [6:0]    max_reg, max_next;
    logic [6:0]    idx_reg, idx_next;
    logic [6:0]    rank_reg, rank_next;
    logic [6:0]    fa_reg, fa_next;
    logic          fa_ok_reg, fa_ok_next, hit_reg, hit_next;
    logic [HC-1:0] pi_reg, pi_next;
    logic signed [31:0] probe_reg, probe_next;
    logic [5:0]    prow_reg;
    logic signed [31:0] fent_reg, hent_reg, plab_rd;
    logic          out_v_reg, out_v_next;

    logic fwr, hwr, pwr;
    logic signed [31:0] probe, entry;
    logic eq, lt;

    gdr_match u_match (.probe(probe), .entry(entry), .eq(eq), .lt(lt));

    always_ff @(posedge aclk) begin
        fent_reg <= fval_mem[idx_reg[FW-1:0]];
        hent_reg <= hval_mem[idx_reg[HW-1:0]];
        plab_rd  <= plab_mem[pi_reg[HW-1:0]];
        prow_reg <= prow_mem[pi_reg[HW-1:0]];
        if (fwr) fval_mem[fcnt_reg[FW-1:0]] <= in_reg.value_a;
        if (hwr) hval_mem[hcnt_reg[HW-1:0]] <= in_reg.value_c;
        if (pwr) begin
            plab_mem[pcnt_reg[HW-1:0]] <= in_reg.value_c;
            prow_mem[pcnt_reg[HW-1:0]] <= 6'(row_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gdr_pkg::ST_IDLE;
            fcnt_reg <= '0; hcnt_reg <= '0; pcnt_reg <= '0;
            row_reg <= '0; max_reg <= '0; out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fcnt_reg <= fcnt_next; hcnt_reg <= hcnt_next; pcnt_reg <= pcnt_next;
            row_reg <= row_next; max_reg <= max_next; out_v_reg <= out_v_next;
        end
        in_reg <= in_next; out_reg <= out_next; idx_reg <= idx_next;
        rank_reg <= rank_next; fa_reg <= fa_next; fa_ok_reg <= fa_ok_next;
        hit_reg <= hit_next; pi_reg <= pi_next; probe_reg <= probe_next;
    end

    assign s_ready = (state_reg == gdr_pkg::ST_IDLE) && !out_v_reg;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    // the table read is registered: the entry under compare has index idx_reg - 1
    logic [6:0] eidx;
    logic [7:0] total;
    assign eidx  = 7'(idx_reg - 1'b1);
    assign total = 8'(fcnt_reg) + 8'(hcnt_reg);

    always_comb begin
        state_next = state_reg; in_next = in_reg; out_next = out_reg;
        fcnt_next = fcnt_reg; hcnt_next = hcnt_reg; pcnt_next = pcnt_reg;
        row_next = row_reg; max_next = max_reg; idx_next = idx_reg;
        rank_next = rank_reg; fa_next = fa_reg; fa_ok_next = fa_ok_reg;
        hit_next = hit_reg; pi_next = pi_reg; probe_next = probe_reg;
        out_v_next = out_v_reg && !m_ready;
        fwr = 1'b0; hwr = 1'b0; pwr = 1'b0;
        probe = probe_reg;
        entry = (state_reg == gdr_pkg::ST_FSCAN || state_reg == gdr_pkg::ST_LFSCAN)
                ? fent_reg : hent_reg;
        unique case (state_reg)
            gdr_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    in_next = s_data;
                    out_next = '0;
                    out_next.last = 1'b1;
                    idx_next = '0; hit_next = 1'b0; fa_ok_next = 1'b0;
                    probe_next = s_data.value_a;
                    unique case (s_data.kind)
                        gdr_pkg::KIND_START: begin
                            fcnt_next = '0; hcnt_next = '0; pcnt_next = '0;
                            row_next = '0;
                            if (s_data.first_marker) max_next = '0;
                        end
                        gdr_pkg::KIND_FOUNDER: state_next = gdr_pkg::ST_FSCAN;
                        gdr_pkg::KIND_HET: begin
                            if (32'(row_reg) >= MAX_HET_ROWS) begin
                                out_next.error = gdr_pkg::ERR_FULL;
                                out_next.max_alleles = max_reg;
                                state_next = gdr_pkg::ST_WAIT;
                            end else begin
                                out_next.row_index = 6'(row_reg);
                                row_next = HC'(row_reg + 1'b1);
                                state_next = gdr_pkg::ST_FSCAN;
                            end
                        end
                        gdr_pkg::KIND_CLOSE: begin
                            if (total > 8'(max_reg)) max_next = 7'(total);
                            pi_next = '0;
                            if (pcnt_reg != '0) state_next = gdr_pkg::ST_LRD;
                        end
                        gdr_pkg::KIND_FINAL: begin
                            if (s_data.is_missing) begin
                                out_next.missing_out = 1'b1;
                                out_next.max_alleles = max_reg;
                                state_next = gdr_pkg::ST_WAIT;
                            end else state_next = gdr_pkg::ST_LFSCAN;
                        end
                        default: ;
                    endcase
                end
            end
            gdr_pkg::ST_FSCAN: begin
                // founder lookup of probe (value_a, then value_b for het rows)
                idx_next = 7'(idx_reg + 1'b1);
                if (idx_reg != '0 && eidx < 7'(fcnt_reg) && eq) begin
                    hit_next = 1'b1; fa_next = eidx;
                    idx_next = 7'(fcnt_reg) + 7'd1;
                end else if (idx_reg > 7'(fcnt_reg)) begin
                    out_next.max_alleles = max_reg;
                    if (in_reg.kind == gdr_pkg::KIND_FOUNDER) begin
                        if (hit_reg) out_next.code_a = fa_reg;
                        else if (32'(fcnt_reg) >= MAX_FOUNDER_ALLELES)
                            out_next.error = gdr_pkg::ERR_FULL;
                        else begin
                            fwr = 1'b1; out_next.code_a = 7'(fcnt_reg);
                            fcnt_next = FC'(fcnt_reg + 1'b1);
                        end
                        state_next = gdr_pkg::ST_WAIT;
                    end else if (!hit_reg) begin
                        out_next.code_a = '0;
                        out_next.error = gdr_pkg::ERR_INVALID;
                        state_next = gdr_pkg::ST_WAIT;
                    end else if (!fa_ok_reg) begin
                        out_next.code_a = fa_reg; fa_ok_next = 1'b1;
                        probe_next = in_reg.value_b; idx_next = '0;
                        hit_next = 1'b0;
                    end else if (in_reg.value_a == in_reg.value_b) begin
                        out_next.code_b = 4'(fa_reg);
                        out_next.code_c = out_reg.code_a;
                        state_next = gdr_pkg::ST_WAIT;
                    end else begin
                        out_next.code_b = 4'(fa_reg);
                        out_next.pending = 1'b1;
                        probe_next = in_reg.value_c; idx_next = '0;
                        hit_next = 1'b0;
                        state_next = gdr_pkg::ST_HSCAN;
                    end
                end
            end
            gdr_pkg::ST_HSCAN: begin
                idx_next = 7'(idx_reg + 1'b1);
                if (idx_reg != '0 && eidx < 7'(hcnt_reg) && eq) begin
                    hit_next = 1'b1; idx_next = 7'(hcnt_reg) + 7'd1;
                end else if (idx_reg > 7'(hcnt_reg)) begin
                    state_next = gdr_pkg::ST_HSCAN2;
                end
            end
            gdr_pkg::ST_HSCAN2: begin
                if (!hit_reg && 32'(hcnt_reg) < MAX_HET_ROWS) begin
                    hwr = 1'b1; hcnt_next = HC'(hcnt_reg + 1'b1);
                end
                if (32'(pcnt_reg) < MAX_HET_ROWS) begin
                    pwr = 1'b1; pcnt_next = HC'(pcnt_reg + 1'b1);
                end
                state_next = gdr_pkg::ST_WAIT;
            end
            gdr_pkg::ST_LRD: begin
                // hold until the previous beat leaves; plab_rd valid from LFSCAN on
                idx_next = '0; hit_next = 1'b0; rank_next = '0;
                if (!out_v_reg || m_ready) state_next = gdr_pkg::ST_LFSCAN;
            end
            gdr_pkg::ST_LFSCAN: begin
                probe = (in_reg.kind == gdr_pkg::KIND_CLOSE) ? plab_rd : in_reg.value_a;
                idx_next = 7'(idx_reg + 1'b1);
                if (idx_reg != '0 && eidx < 7'(fcnt_reg) && eq) begin
                    hit_next = 1'b1; fa_next = eidx;
                    idx_next = 7'(fcnt_reg) + 7'd1;
                end else if (idx_reg > 7'(fcnt_reg)) begin
                    idx_next = '0; rank_next = '0;
                    state_next = gdr_pkg::ST_LHSCAN;
                end
            end
            gdr_pkg::ST_LHSCAN: begin
                probe = (in_reg.kind == gdr_pkg::KIND_CLOSE) ? plab_rd : in_reg.value_a;
                idx_next = 7'(idx_reg + 1'b1);
                if (idx_reg != '0 && eidx < 7'(hcnt_reg)) begin
                    if (lt) rank_next = 7'(rank_reg + 1'b1);
                    if (eq) fa_ok_next = 1'b1;
                end
                if (hit_reg || idx_reg > 7'(hcnt_reg)) begin
                    out_next = '0;
                    out_next.max_alleles = max_reg;
                    if (hit_reg) out_next.code_c = fa_reg;
                    else if (fa_ok_reg) out_next.code_c = 7'(7'(fcnt_reg) + rank_reg);
                    else out_next.error = gdr_pkg::ERR_INVALID;
                    if (in_reg.kind == gdr_pkg::KIND_CLOSE) begin
                        out_next.row_index = prow_reg;
                        out_next.last = (HC'(pi_reg + 1'b1) == pcnt_reg);
                        if (out_next.error != gdr_pkg::ERR_OK) out_next.code_c = '0;
                    end else begin
                        out_next.code_a = out_next.code_c;
                        out_next.code_c = '0;
                        out_next.last = 1'b1;
                    end
                    state_next = gdr_pkg::ST_EMIT;
                end
            end
            gdr_pkg::ST_EMIT: begin
                if (!out_v_reg || m_ready) begin
                    out_v_next = 1'b1;
                    fa_ok_next = 1'b0;
                    if (out_reg.last) begin
                        if (in_reg.kind == gdr_pkg::KIND_CLOSE) pcnt_next = '0;
                        state_next = gdr_pkg::ST_IDLE;
                    end else begin
                        pi_next = HC'(pi_reg + 1'b1);
                        state_next = gdr_pkg::ST_LRD;
                    end
                end
            end
            gdr_pkg::ST_WAIT: begin
                out_v_next = 1'b1;
                state_next = gdr_pkg::ST_IDLE;
            end
            default: state_next = gdr_pkg::ST_IDLE;
        endcase
    end
endmodule
